/* hdl/top_k_sorted_score_insert_defines.svh */
// Assertion macros for the top-k sorted score list.
// Included by modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef TOP_K_SORTED_SCORE_INSERT_DEFINES_SVH
`define TOP_K_SORTED_SCORE_INSERT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define TKS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("top-k list: same-cycle check failed");

// Next-cycle implication, disabled in reset.
`define TKS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("top-k list: next-cycle check failed");

`endif

/* hdl/tkssi_pkg.sv */
// Shared types and request codes for the top-k sorted score list.
// No dependencies.
`timescale 1ns / 1ps

package tkssi_pkg;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

/* hdl/tkssi_ctrl.sv */
// Request sequencer for the top-k sorted score list.
// Depends on tkssi_pkg and top_k_sorted_score_insert_defines.svh.
`timescale 1ns / 1ps
`include "top_k_sorted_score_insert_defines.svh"

module tkssi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  output logic             done_o,
  output tkssi_pkg::cmd_t  cmd_o
);
  import tkssi_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state_q <= ST_IDLE;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy_o        = (state_q == ST_EXEC);
  assign done_o        = done_q;
  assign cmd_o.capture = start_i && (state_q == ST_IDLE);
  assign cmd_o.execute = (state_q == ST_EXEC);

  `TKS_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `TKS_ASSERT_NEXT(a_exec_done, cmd_o.execute, done_o && !busy_o)
  `TKS_ASSERT_NOW(a_done_idle, done_o, !cmd_o.execute)
  `TKS_ASSERT_NOW(a_cmd_excl, 1'b1, !(cmd_o.capture && cmd_o.execute))

endmodule

/* hdl/tkssi_datapath.sv */
// Sorted score and tag register file with parallel compare and shift.
// Depends on tkssi_pkg.
`timescale 1ns / 1ps

module tkssi_datapath #(
  parameter int DEPTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tkssi_pkg::cmd_t  cmd_i,
  input  logic [1:0]       req_type_i,
  input  logic [15:0]      item_score_i,
  input  logic [15:0]      item_tag_i,
  input  logic [2:0]       read_slot_i,
  output logic             was_stored_o,
  output logic [2:0]       stored_slot_o,
  output logic [3:0]       entry_count_o,
  output logic [15:0]      slot_score_o,
  output logic [15:0]      slot_tag_o
);
  import tkssi_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [1:0]    req_q;
  logic [15:0]   req_score_q;
  logic [15:0]   req_tag_q;
  logic [2:0]    req_slot_q;

  logic [15:0]   score_q [DEPTH];
  logic [15:0]   tag_q   [DEPTH];
  logic [15:0]   score_d [DEPTH];
  logic [15:0]   tag_d   [DEPTH];
  logic [15:0]   shift_score [DEPTH];
  logic [15:0]   shift_tag   [DEPTH];
  logic [CW-1:0] count_q;

  logic [DEPTH-1:0] lower;
  logic [DEPTH-1:0] boundary;
  logic             found;
  logic [IW-1:0]    pos;
  logic             prev_lower;
  logic             rd_hit;
  logic [IW-1:0]    rd_idx;

  logic          was_stored_q;
  logic [2:0]    stored_slot_q;
  logic [15:0]   slot_score_q;
  logic [15:0]   slot_tag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q       <= req_type_i;
      req_score_q <= item_score_i;
      req_tag_q   <= item_tag_i;
      req_slot_q  <= read_slot_i;
    end
  end

  // Stored scores stay in descending order, so the lower flags form a thermometer.
  always_comb begin
    prev_lower = 1'b0;
    pos        = '0;
    for (int j = 0; j < DEPTH; j++) begin
      lower[j]    = req_score_q > score_q[j];
      boundary[j] = lower[j] && !prev_lower;
      prev_lower  = lower[j];
      if (boundary[j]) begin
        pos = pos | IW'(j);
      end
    end
    found = |lower;
  end

  always_comb begin
    shift_score[0] = req_score_q;
    shift_tag[0]   = req_tag_q;
    for (int j = 1; j < DEPTH; j++) begin
      shift_score[j] = score_q[j-1];
      shift_tag[j]   = tag_q[j-1];
    end
    for (int j = 0; j < DEPTH; j++) begin
      if (boundary[j]) begin
        score_d[j] = req_score_q;
        tag_d[j]   = req_tag_q;
      end else if (lower[j]) begin
        score_d[j] = shift_score[j];
        tag_d[j]   = shift_tag[j];
      end else begin
        score_d[j] = score_q[j];
        tag_d[j]   = tag_q[j];
      end
    end
  end

  assign rd_hit = 32'(req_slot_q) < DEPTH;
  assign rd_idx = IW'(req_slot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < DEPTH; j++) begin
        score_q[j] <= '0;
        tag_q[j]   <= '0;
      end
      count_q <= '0;
    end else if (cmd_i.execute) begin
      case (req_q)
        REQ_CLEAR: begin
          for (int j = 0; j < DEPTH; j++) begin
            score_q[j] <= '0;
          end
          count_q <= '0;
        end
        REQ_INSERT: begin
          for (int j = 0; j < DEPTH; j++) begin
            score_q[j] <= score_d[j];
            tag_q[j]   <= tag_d[j];
          end
          if (found && (32'(count_q) < DEPTH)) begin
            count_q <= count_q + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      was_stored_q  <= (req_q == REQ_INSERT) && found;
      stored_slot_q <= ((req_q == REQ_INSERT) && found) ? 3'(pos) : 3'd0;
      if ((req_q == REQ_READ) && rd_hit) begin
        slot_score_q <= score_q[rd_idx];
        slot_tag_q   <= tag_q[rd_idx];
      end else begin
        slot_score_q <= '0;
        slot_tag_q   <= '0;
      end
    end
  end

  assign was_stored_o  = was_stored_q;
  assign stored_slot_o = stored_slot_q;
  assign entry_count_o = 4'(count_q);
  assign slot_score_o  = slot_score_q;
  assign slot_tag_o    = slot_tag_q;

endmodule

/* hdl/top_k_sorted_score_insert.sv */
// Top-k sorted score list: a request taken at start && !busy is captured, then run
// by the single execute state that compares and shifts all DEPTH slots in parallel;
// its result is registered and flagged by done_o, and no new request is taken while busy.
// Results are strobed for one cycle and cannot be stalled by the receiver.
// Reset (rst_ni low, asynchronous) zeroes all scores, tags and the entry count.
`timescale 1ns / 1ps

module top_k_sorted_score_insert #(
  parameter int DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic [1:0]  req_type_i,
  input  logic [15:0] item_score_i,
  input  logic [15:0] item_tag_i,
  input  logic [2:0]  read_slot_i,
  output logic        was_stored_o,
  output logic [2:0]  stored_slot_o,
  output logic [3:0]  entry_count_o,
  output logic [15:0] slot_score_o,
  output logic [15:0] slot_tag_o
);
  import tkssi_pkg::*;

  cmd_t cmd;

  tkssi_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  tkssi_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_type_i    (req_type_i),
    .item_score_i  (item_score_i),
    .item_tag_i    (item_tag_i),
    .read_slot_i   (read_slot_i),
    .was_stored_o  (was_stored_o),
    .stored_slot_o (stored_slot_o),
    .entry_count_o (entry_count_o),
    .slot_score_o  (slot_score_o),
    .slot_tag_o    (slot_tag_o)
  );

endmodule
